### hw/rtl/sm2_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sm2_pkg;
   localparam logic [255:0] Prime =
      256'hFFFFFFFEFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFF00000000FFFFFFFFFFFFFFFF;

   typedef enum logic [2:0] {
      CMD_ADD = 3'd0, CMD_SUB = 3'd1, CMD_NEG = 3'd2, CMD_DBL = 3'd3,
      CMD_HALF = 3'd4, CMD_MUL = 3'd5, CMD_SQR = 3'd6, CMD_INV = 3'd7
   } cmd_type;

   typedef struct packed {
      logic [2:0]  command;
      logic [63:0] a_word0;
      logic [63:0] a_word1;
      logic [63:0] a_word2;
      logic [63:0] a_word3;
      logic [63:0] b_word0;
      logic [63:0] b_word1;
      logic [63:0] b_word2;
      logic [63:0] b_word3;
   } req_type;

   typedef struct packed {
      logic [63:0] res_word0;
      logic [63:0] res_word1;
      logic [63:0] res_word2;
      logic [63:0] res_word3;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_REDA, ST_REDB, ST_DISPATCH, ST_SIMPLE, ST_FIX,
      ST_MULD, ST_MULA, ST_INVCHK, ST_INVU, ST_INVV, ST_INVSUB, ST_INVX, ST_DONE
   } state_type;

   // operation selected for the shared modular adder
   typedef enum logic [1:0] {
      OP_ADD, OP_SUB, OP_HALF, OP_PASS
   } op_type;

   typedef struct packed {
      op_type       op;
      logic [255:0] x;
      logic [255:0] y;
   } alu_req_type;
endpackage
`default_nettype wire

### hw/rtl/sm2_modadd.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared modular add/sub/halve unit; inputs below p, output below p.
module sm2_modadd (
   input  wire sm2_pkg::alu_req_type alu_req,
   output logic [255:0]              alu_res
);
   logic [256:0] sum;
   logic [256:0] red;
   logic [256:0] dif;
   logic [256:0] half_sum;

   always_comb begin
      sum      = {1'b0, alu_req.x} + {1'b0, alu_req.y};
      red      = sum - {1'b0, sm2_pkg::Prime};
      dif      = {1'b0, alu_req.x} - {1'b0, alu_req.y};
      half_sum = {1'b0, alu_req.x} + (alu_req.x[0] ? {1'b0, sm2_pkg::Prime} : 257'd0);
      case (alu_req.op)
         sm2_pkg::OP_ADD:  alu_res = red[256] ? sum[255:0] : red[255:0];
         sm2_pkg::OP_SUB:  alu_res = dif[256] ? (dif[255:0] + sm2_pkg::Prime) : dif[255:0];
         sm2_pkg::OP_HALF: alu_res = half_sum[256:1];
         default:          alu_res = alu_req.x;
      endcase
   end
endmodule
`default_nettype wire

### hw/rtl/sm2_prime_field_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel | Dir | Payload             | Handshake
// req     | in  | sm2_pkg::req_type   | req_valid / req_ready
// rsp     | out | sm2_pkg::rsp_type   | rsp_valid / rsp_ready
//
// One item at a time through one shared 256-bit modular adder under a sequencer.
// Add/sub/neg/double/half: REDA, REDB and DISPATCH, then one adder pass in SIMPLE.
// Mul/square: double-and-add over 256 bits of b, two adder passes per bit.
// Inverse: data-dependent binary Euclid; halve u, v while even, then subtract.
// Synchronous active-high reset returns the sequencer to idle.
// req_ready is high only in idle; the result stays on rsp until taken.
module sm2_prime_field_alu (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  wire sm2_pkg::req_type   req_data,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output sm2_pkg::rsp_type        rsp_data
);
   sm2_pkg::state_type state_ff, state_in;
   sm2_pkg::cmd_type   cmd_ff;
   logic [255:0] a_ff, a_in, b_ff, b_in;
   logic [255:0] u_ff, u_in, v_ff, v_in;   // inverse: u, v; mul: acc in u
   logic [255:0] x1_ff, x1_in, x2_ff, x2_in;
   logic [7:0]   cnt_ff, cnt_in;
   logic [255:0] res_ff, res_in;
   sm2_pkg::alu_req_type alu_req;
   logic [255:0] alu_res;
   logic         u_one, v_one, u_ge_v, a_ge_p, b_ge_p;

   sm2_modadd u_modadd (.alu_req(alu_req), .alu_res(alu_res));

   assign u_one  = (u_ff == 256'd1);
   assign v_one  = (v_ff == 256'd1);
   assign u_ge_v = (u_ff >= v_ff);
   assign a_ge_p = (a_ff >= sm2_pkg::Prime);
   assign b_ge_p = (b_ff >= sm2_pkg::Prime);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sm2_pkg::ST_IDLE:     if (req_valid) state_in = sm2_pkg::ST_REDA;
         sm2_pkg::ST_REDA:     state_in = sm2_pkg::ST_REDB;
         sm2_pkg::ST_REDB:     state_in = sm2_pkg::ST_DISPATCH;
         sm2_pkg::ST_DISPATCH: begin
            case (cmd_ff)
               sm2_pkg::CMD_MUL, sm2_pkg::CMD_SQR: state_in = sm2_pkg::ST_MULD;
               sm2_pkg::CMD_INV: state_in = sm2_pkg::ST_INVCHK;
               default:          state_in = sm2_pkg::ST_SIMPLE;
            endcase
         end
         sm2_pkg::ST_SIMPLE:   state_in = sm2_pkg::ST_DONE;
         sm2_pkg::ST_MULD:     state_in = sm2_pkg::ST_MULA;
         sm2_pkg::ST_MULA:     state_in = (cnt_ff == 8'd0) ? sm2_pkg::ST_FIX
                                                             : sm2_pkg::ST_MULD;
         sm2_pkg::ST_FIX:      state_in = sm2_pkg::ST_DONE;
         sm2_pkg::ST_INVCHK:
            if (u_one || v_one) state_in = sm2_pkg::ST_FIX;
            else                state_in = sm2_pkg::ST_INVU;
         sm2_pkg::ST_INVU:     if (u_ff[0]) state_in = sm2_pkg::ST_INVV;
         sm2_pkg::ST_INVV:     if (v_ff[0]) state_in = sm2_pkg::ST_INVSUB;
         sm2_pkg::ST_INVSUB:   state_in = sm2_pkg::ST_INVX;
         sm2_pkg::ST_INVX:     state_in = sm2_pkg::ST_INVCHK;
         sm2_pkg::ST_DONE:     if (rsp_ready) state_in = sm2_pkg::ST_IDLE;
         default:              state_in = sm2_pkg::ST_IDLE;
      endcase
   end

   // adder operand selection and datapath updates
   always_comb begin
      a_in  = a_ff;  b_in  = b_ff;  u_in = u_ff;  v_in = v_ff;
      x1_in = x1_ff; x2_in = x2_ff; cnt_in = cnt_ff; res_in = res_ff;
      alu_req.op = sm2_pkg::OP_PASS;
      alu_req.x  = a_ff;
      alu_req.y  = b_ff;
      case (state_ff)
         sm2_pkg::ST_IDLE: begin
            a_in = {req_data.a_word3, req_data.a_word2, req_data.a_word1, req_data.a_word0};
            b_in = {req_data.b_word3, req_data.b_word2, req_data.b_word1, req_data.b_word0};
         end
         sm2_pkg::ST_REDA: if (a_ge_p) a_in = a_ff - sm2_pkg::Prime;
         sm2_pkg::ST_REDB: if (b_ge_p) b_in = b_ff - sm2_pkg::Prime;
         sm2_pkg::ST_DISPATCH: begin
            if (cmd_ff == sm2_pkg::CMD_SQR) b_in = a_ff;
            if (cmd_ff == sm2_pkg::CMD_INV) begin
               u_in = a_ff; v_in = sm2_pkg::Prime;
               x1_in = 256'd1; x2_in = 256'd0;
            end else begin
               u_in = 256'd0;
            end
            cnt_in = 8'd255;
         end
         sm2_pkg::ST_SIMPLE: begin
            case (cmd_ff)
               sm2_pkg::CMD_ADD: alu_req.op = sm2_pkg::OP_ADD;
               sm2_pkg::CMD_SUB: alu_req.op = sm2_pkg::OP_SUB;
               sm2_pkg::CMD_NEG: begin
                  alu_req.op = sm2_pkg::OP_SUB; alu_req.x = 256'd0; alu_req.y = a_ff;
               end
               sm2_pkg::CMD_DBL: begin alu_req.op = sm2_pkg::OP_ADD; alu_req.y = a_ff; end
               default:          alu_req.op = sm2_pkg::OP_HALF;
            endcase
            res_in = alu_res;
         end
         sm2_pkg::ST_MULD: begin
            alu_req.op = sm2_pkg::OP_ADD; alu_req.x = u_ff; alu_req.y = u_ff;
            u_in = alu_res;
         end
         sm2_pkg::ST_MULA: begin
            alu_req.op = b_ff[255] ? sm2_pkg::OP_ADD : sm2_pkg::OP_PASS;
            alu_req.x = u_ff; alu_req.y = a_ff;
            u_in = alu_res;
            b_in = {b_ff[254:0], 1'b0};
            cnt_in = cnt_ff - 8'd1;
         end
         sm2_pkg::ST_FIX: begin
            // zero operand to inverse yields zero; mul result sits in u
            if (cmd_ff != sm2_pkg::CMD_INV) res_in = u_ff;
            else if (a_ff == 256'd0)        res_in = 256'd0;
            else                            res_in = u_one ? x1_ff : x2_ff;
         end
         sm2_pkg::ST_INVCHK: if (a_ff == 256'd0) u_in = 256'd1;
         sm2_pkg::ST_INVU: if (!u_ff[0]) begin
            u_in = {1'b0, u_ff[255:1]};
            alu_req.op = sm2_pkg::OP_HALF; alu_req.x = x1_ff;
            x1_in = alu_res;
         end
         sm2_pkg::ST_INVV: if (!v_ff[0]) begin
            v_in = {1'b0, v_ff[255:1]};
            alu_req.op = sm2_pkg::OP_HALF; alu_req.x = x2_ff;
            x2_in = alu_res;
         end
         sm2_pkg::ST_INVSUB: begin
            if (u_ge_v) u_in = u_ff - v_ff;
            else        v_in = v_ff - u_ff;
            cnt_in = {7'd0, u_ge_v};
         end
         sm2_pkg::ST_INVX: begin
            alu_req.op = sm2_pkg::OP_SUB;
            if (cnt_ff[0]) begin
               alu_req.x = x1_ff; alu_req.y = x2_ff; x1_in = alu_res;
            end else begin
               alu_req.x = x2_ff; alu_req.y = x1_ff; x2_in = alu_res;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= sm2_pkg::ST_IDLE;
      else       state_ff <= state_in;
      if (state_ff == sm2_pkg::ST_IDLE) cmd_ff <= sm2_pkg::cmd_type'(req_data.command);
      a_ff <= a_in; b_ff <= b_in; u_ff <= u_in; v_ff <= v_in;
      x1_ff <= x1_in; x2_ff <= x2_in; cnt_ff <= cnt_in; res_ff <= res_in;
   end

   // outputs
   always_comb begin
      req_ready = (state_ff == sm2_pkg::ST_IDLE);
      rsp_valid = (state_ff == sm2_pkg::ST_DONE);
      rsp_data.res_word0 = res_ff[63:0];
      rsp_data.res_word1 = res_ff[127:64];
      rsp_data.res_word2 = res_ff[191:128];
      rsp_data.res_word3 = res_ff[255:192];
   end
endmodule
`default_nettype wire
